// ----- rtl/iirc_pkg.sv -----
// ----------------------------------------------------------------------------
// iirc_pkg : shared constants and types for the clamped IIR biquad
// Field widths, fixed-point layout, operation and register codes, and the
// control/status bundles passed between the sequencer and the serial MAC.
// ----------------------------------------------------------------------------
package iirc_pkg;

    localparam int SAMPLE_W  = 16;            // input/output sample width
    localparam int COEF_W    = 18;            // Q4.14 coefficients and gain
    localparam int FRAC_W    = 14;            // fractional bits of a coefficient
    localparam int ROUND_SH  = 2 * FRAC_W;    // binary point of the accumulator
    localparam int ACC_W     = 56;            // accumulator, covers the full sum
    localparam int DIGIT_W   = 4;             // multiplier digit per cycle
    localparam int MULT_W    = 20;            // serial operand, whole digits
    localparam int NARROW_DIGITS = SAMPLE_W / DIGIT_W;
    localparam int WIDE_DIGITS   = MULT_W / DIGIT_W;
    localparam int CNT_W     = 3;             // holds WIDE_DIGITS
    localparam int RND_W     = ACC_W - ROUND_SH + 1;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;
    localparam int NUM_TAPS  = 3;
    localparam int DEN_TAPS  = 2;
    localparam int ORDER_DEF = 2;

    localparam logic signed [COEF_W-1:0] UNITY_RST = COEF_W'(16384);

    // Product terms in the order they are accumulated
    typedef enum logic [2:0] {
        OP_N0   = 3'd0,
        OP_N1   = 3'd1,
        OP_N2   = 3'd2,
        OP_GAIN = 3'd3,
        OP_D0   = 3'd4,
        OP_D1   = 3'd5
    } t_op;

    // Register map, word index
    typedef enum logic [2:0] {
        REG_NUM0  = 3'd0,
        REG_NUM1  = 3'd1,
        REG_NUM2  = 3'd2,
        REG_DEN0  = 3'd3,
        REG_DEN1  = 3'd4,
        REG_GAIN  = 3'd5,
        REG_UPPER = 3'd6,
        REG_LOWER = 3'd7
    } t_reg;

    typedef struct packed {
        logic start;   // load operands and begin
        logic clr;     // clear accumulator on load
        logic neg;     // subtract the product
        logic wide;    // serial operand uses all digits
    } t_mac_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mac_sts;

endpackage

// ----- rtl/iirc_dmac.sv -----
// ----------------------------------------------------------------------------
// iirc_dmac : digit-serial multiply-accumulate
// Consumes the serial operand one 4-bit digit per cycle, least significant
// first; the top digit carries the sign weight.
// ----------------------------------------------------------------------------
module iirc_dmac (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  iirc_pkg::t_mac_ctl                  i_ctl,
    input  logic signed [iirc_pkg::ACC_W-1:0]   i_a,
    input  logic signed [iirc_pkg::MULT_W-1:0]  i_b,
    output iirc_pkg::t_mac_sts                  o_sts,
    output logic signed [iirc_pkg::ACC_W-1:0]   o_acc
);
    import iirc_pkg::*;

    logic                      r_busy;
    logic                      r_done;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_neg;
    logic signed [ACC_W-1:0]   r_a;
    logic [MULT_W-1:0]         r_b;
    logic signed [ACC_W-1:0]   r_acc;

    logic [DIGIT_W-1:0]        w_digit;
    logic                      w_last;
    logic signed [DIGIT_W:0]   w_sdig;
    logic signed [ACC_W+DIGIT_W:0] w_prod;
    logic signed [ACC_W-1:0]   w_term;

    assign w_digit = r_b[DIGIT_W-1:0];
    assign w_last  = (r_cnt == CNT_W'(1));
    // sign weight only on the top digit
    assign w_sdig  = {w_last & w_digit[DIGIT_W-1], w_digit};
    assign w_prod  = r_a * w_sdig;
    assign w_term  = w_prod[ACC_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_ctl.wide ? CNT_W'(WIDE_DIGITS) : CNT_W'(NARROW_DIGITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_neg <= i_ctl.neg;
            r_a   <= i_a;
            r_b   <= i_b;
            if (i_ctl.clr) begin
                r_acc <= '0;
            end
        end else if (r_busy) begin
            r_acc <= r_neg ? (r_acc - w_term) : (r_acc + w_term);
            r_a   <= r_a <<< DIGIT_W;
            r_b   <= r_b >> DIGIT_W;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_acc      = r_acc;

endmodule

// ----- rtl/iirc_post.sv -----
// ----------------------------------------------------------------------------
// iirc_post : round, saturate and clamp
// Rounds the Q28 accumulator to nearest (ties up), saturates to 16 bits with
// a flag, then applies the optional upper and lower limits.
// ----------------------------------------------------------------------------
module iirc_post (
    input  logic signed [iirc_pkg::ACC_W-1:0]    i_acc,
    input  logic signed [iirc_pkg::SAMPLE_W-1:0] i_upper,
    input  logic signed [iirc_pkg::SAMPLE_W-1:0] i_lower,
    output logic signed [iirc_pkg::SAMPLE_W-1:0] o_sample,
    output logic                                 o_ovf
);
    import iirc_pkg::*;

    localparam logic signed [RND_W-1:0] SAT_MAX = RND_W'((2 ** (SAMPLE_W - 1)) - 1);
    localparam logic signed [RND_W-1:0] SAT_MIN = -RND_W'(2 ** (SAMPLE_W - 1));

    logic signed [RND_W-1:0]    w_rnd;
    logic                       w_hi;
    logic                       w_lo;
    logic signed [SAMPLE_W-1:0] w_sat;
    logic signed [SAMPLE_W-1:0] w_up;

    // floor(acc / 2^28) plus the half bit
    assign w_rnd = {i_acc[ACC_W-1], i_acc[ACC_W-1:ROUND_SH]}
                 + {{(RND_W-1){1'b0}}, i_acc[ROUND_SH-1]};
    assign w_hi  = (w_rnd > SAT_MAX);
    assign w_lo  = (w_rnd < SAT_MIN);

    always_comb begin
        if (w_hi) begin
            w_sat = SAT_MAX[SAMPLE_W-1:0];
        end else if (w_lo) begin
            w_sat = SAT_MIN[SAMPLE_W-1:0];
        end else begin
            w_sat = w_rnd[SAMPLE_W-1:0];
        end
        w_up     = ((i_upper != '0) && (w_sat > i_upper)) ? i_upper : w_sat;
        o_sample = ((i_lower != '0) && (w_up < i_lower)) ? i_lower : w_up;
    end

    assign o_ovf = w_hi | w_lo;

endmodule

// ----- rtl/iir_filter_with_output_clamp_unit.sv -----
// ----------------------------------------------------------------------------
// iir_filter_with_output_clamp_unit : second-order IIR, direct form I, clamped
// Filters signed 16-bit samples with Q4.14 coefficients and gain, rounds and
// saturates the result, then clamps it to programmable limits.
// ----------------------------------------------------------------------------
// Usage
//   Input channel : i_in_valid / o_in_stall with i_sample_in. One beat per
//   sample; o_in_stall is high while a sample is being worked on.
//   Output channel: o_out_valid / i_out_stall with o_sample_out and
//   o_overflowed, one beat per input beat, in order.
//   APB port: eight word registers (numerator 0..2, denominator 0..1, gain,
//   upper and lower limit) at byte address 4*index; write only while idle.
// Sequencing
//   All products run through one digit-serial MAC, 4 bits of the serial
//   operand per cycle: samples use 4 digits, the gain 5. With ORDER 2 each
//   sample takes three numerator products, the gain product and two
//   feedback products; ORDER 1 drops the oldest numerator and feedback
//   taps. A new sample is taken only once the previous one has left the
//   finishing step.
// Reset and back-pressure
//   Reset clears histories, limits and coefficients (numerator 2 and gain to
//   unity). A finished beat waits in the output register while the receiver
//   stalls; the next sample is still taken and computed, and its finishing
//   step holds until the output register frees.
// ----------------------------------------------------------------------------
module iir_filter_with_output_clamp_unit #(
    parameter int ORDER = iirc_pkg::ORDER_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [iirc_pkg::SAMPLE_W-1:0] i_sample_in,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [iirc_pkg::SAMPLE_W-1:0] o_sample_out,
    output logic                                 o_overflowed,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [iirc_pkg::ADDR_W-1:0]          paddr,
    input  logic [iirc_pkg::DATA_W-1:0]          pwdata,
    output logic [iirc_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready
);
    import iirc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_ISSUE  = 4'b0010,
        S_WAIT   = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    // first tap used; reduced order drops the oldest terms
    localparam t_op FIRST_OP = (ORDER >= 2) ? OP_N0 : OP_N1;

    // ---- configuration registers
    logic signed [COEF_W-1:0]   r_num [NUM_TAPS];
    logic signed [COEF_W-1:0]   r_den [DEN_TAPS];
    logic signed [COEF_W-1:0]   r_gain;
    logic signed [SAMPLE_W-1:0] r_upper;
    logic signed [SAMPLE_W-1:0] r_lower;

    // ---- filter state
    logic signed [SAMPLE_W-1:0] r_x_hist [NUM_TAPS];   // oldest first
    logic signed [SAMPLE_W-1:0] r_y_hist [DEN_TAPS];   // oldest first

    t_state r_state;
    t_state n_state;
    t_op    r_op;
    t_op    n_op;

    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_sample_out;
    logic                       r_overflowed;

    logic                       w_cfg_wr;
    t_reg                       w_reg;
    logic                       w_in_acc;
    logic                       w_load_out;
    t_mac_ctl                   w_ctl;
    t_mac_sts                   w_sts;
    logic signed [ACC_W-1:0]    w_a;
    logic signed [MULT_W-1:0]   w_b;
    logic signed [ACC_W-1:0]    w_acc;
    logic signed [SAMPLE_W-1:0] w_y;
    logic                       w_ovf;

    // ---- APB register file
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite;
    assign w_reg    = t_reg'(paddr[ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num[0] <= '0;
            r_num[1] <= '0;
            r_num[2] <= UNITY_RST;
            r_den[0] <= '0;
            r_den[1] <= '0;
            r_gain   <= UNITY_RST;
            r_upper  <= '0;
            r_lower  <= '0;
        end else if (w_cfg_wr) begin
            unique case (w_reg)
                REG_NUM0:  r_num[0] <= pwdata[COEF_W-1:0];
                REG_NUM1:  r_num[1] <= pwdata[COEF_W-1:0];
                REG_NUM2:  r_num[2] <= pwdata[COEF_W-1:0];
                REG_DEN0:  r_den[0] <= pwdata[COEF_W-1:0];
                REG_DEN1:  r_den[1] <= pwdata[COEF_W-1:0];
                REG_GAIN:  r_gain   <= pwdata[COEF_W-1:0];
                REG_UPPER: r_upper  <= pwdata[SAMPLE_W-1:0];
                REG_LOWER: r_lower  <= pwdata[SAMPLE_W-1:0];
                default:   r_lower  <= r_lower;
            endcase
        end
    end

    // read back sign-extended
    always_comb begin
        unique case (w_reg)
            REG_NUM0:  prdata = DATA_W'(r_num[0]);
            REG_NUM1:  prdata = DATA_W'(r_num[1]);
            REG_NUM2:  prdata = DATA_W'(r_num[2]);
            REG_DEN0:  prdata = DATA_W'(r_den[0]);
            REG_DEN1:  prdata = DATA_W'(r_den[1]);
            REG_GAIN:  prdata = DATA_W'(r_gain);
            REG_UPPER: prdata = DATA_W'(r_upper);
            REG_LOWER: prdata = DATA_W'(r_lower);
            default:   prdata = '0;
        endcase
    end

    // ---- input side: take a beat only when idle
    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid & (r_state == S_IDLE);

    // ---- output side: finishing step waits for a free output register
    assign w_load_out = (r_state == S_FINISH) & (~r_out_valid | ~i_out_stall);

    // ---- product sequence
    always_comb begin
        unique case (r_op)
            OP_N0:   n_op = OP_N1;
            OP_N1:   n_op = OP_N2;
            OP_N2:   n_op = OP_GAIN;
            OP_GAIN: n_op = (ORDER >= 2) ? OP_D0 : OP_D1;
            OP_D0:   n_op = OP_D1;
            default: n_op = OP_D1;
        endcase
    end

    // operand select: sum the numerator taps, scale by gain, subtract the
    // feedback taps shifted up to the Q28 point
    always_comb begin
        w_ctl.start = (r_state == S_ISSUE);
        w_ctl.clr   = (r_op == FIRST_OP) || (r_op == OP_GAIN);
        w_ctl.neg   = (r_op == OP_D0) || (r_op == OP_D1);
        w_ctl.wide  = (r_op == OP_GAIN);
        unique case (r_op)
            OP_N0: begin
                w_a = ACC_W'(r_num[0]);
                w_b = MULT_W'(r_x_hist[0]);
            end
            OP_N1: begin
                w_a = ACC_W'(r_num[1]);
                w_b = MULT_W'(r_x_hist[1]);
            end
            OP_N2: begin
                w_a = ACC_W'(r_num[2]);
                w_b = MULT_W'(r_x_hist[2]);
            end
            OP_GAIN: begin
                w_a = w_acc;
                w_b = MULT_W'(r_gain);
            end
            OP_D0: begin
                w_a = ACC_W'(r_den[0]) <<< FRAC_W;
                w_b = MULT_W'(r_y_hist[0]);
            end
            default: begin
                w_a = ACC_W'(r_den[1]) <<< FRAC_W;
                w_b = MULT_W'(r_y_hist[1]);
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (w_in_acc) n_state = S_ISSUE;
            S_ISSUE:  n_state = S_WAIT;
            S_WAIT: begin
                if (w_sts.done) begin
                    n_state = (r_op == OP_D1) ? S_FINISH : S_ISSUE;
                end
            end
            S_FINISH: if (w_load_out) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= FIRST_OP;
            r_out_valid <= 1'b0;
            r_x_hist[0] <= '0;
            r_x_hist[1] <= '0;
            r_x_hist[2] <= '0;
            r_y_hist[0] <= '0;
            r_y_hist[1] <= '0;
        end else begin
            r_state <= n_state;
            if (w_in_acc) begin
                // shift the newest sample in
                r_x_hist[0] <= r_x_hist[1];
                r_x_hist[1] <= r_x_hist[2];
                r_x_hist[2] <= i_sample_in;
                r_op        <= FIRST_OP;
            end else if ((r_state == S_WAIT) && w_sts.done && (r_op != OP_D1)) begin
                r_op <= n_op;
            end
            if (w_load_out) begin
                r_y_hist[0] <= r_y_hist[1];
                r_y_hist[1] <= w_y;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_sample_out <= w_y;
            r_overflowed <= w_ovf;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_sample_out;
    assign o_overflowed = r_overflowed;

    iirc_dmac u_dmac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_sts   (w_sts),
        .o_acc   (w_acc)
    );

    iirc_post u_post (
        .i_acc    (w_acc),
        .i_upper  (r_upper),
        .i_lower  (r_lower),
        .o_sample (w_y),
        .o_ovf    (w_ovf)
    );

    // ---- checks
    a_mac_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_sts.busy)
        else $error("MAC busy while sequencer idle");

    a_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.done |-> (r_state == S_WAIT))
        else $error("MAC finished outside wait state");

    a_out_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_FINISH))
        else $error("output beat not produced by finishing step");

endmodule
